FILE: rtl/lgts_pkg.sv
// ----------------------------------------------------------------------------
// lgts_pkg: shared constants for the LDA Gibbs topic sampler
// Sizes, field widths, function codes and fixed-point widths.
// ----------------------------------------------------------------------------
package lgts_pkg;

	localparam int NUM_TOPICS = 64;
	localparam int VOCAB_SIZE = 4096;
	localparam int NUM_DOCS   = 1024;
	localparam int COUNT_BITS = 24;

	localparam int TOPIC_W = $clog2(NUM_TOPICS);
	localparam int WORD_W  = $clog2(VOCAB_SIZE);
	localparam int DOC_W   = $clog2(NUM_DOCS);
	localparam int DT_AW   = DOC_W + TOPIC_W;
	localparam int TW_AW   = TOPIC_W + WORD_W;

	localparam int HYP_W  = 32;
	localparam int UNI_W  = 32;
	localparam int FUNC_W = 2;
	// operand of the weight: count in Q24.16 plus a 32-bit prior
	localparam int OP_W   = COUNT_BITS + 17;
	localparam int PROD_W = 2 * OP_W;
	localparam int LO_W   = (OP_W + 1) / 2;
	localparam int HI_W   = OP_W - LO_W;
	localparam int WGT_W  = 48;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [WGT_W-1:0]      WGT_MAX = '1;

	localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RES   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ALPHA = 2'd2;

	localparam logic REG_BETA       = 1'b0;
	localparam logic REG_TOTAL_BETA = 1'b1;

endpackage

FILE: rtl/lda_gibbs_topic_sampler.sv
// ----------------------------------------------------------------------------
// lda_gibbs_topic_sampler: collapsed Gibbs topic sampler
// Keeps LDA count tables in on-chip memories and resamples token topics.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on the s_ group; tuser carries the function code and
//   tdata the token fields. Each input beat yields exactly one output beat on
//   the m_ group: the topic now held by the token and a count error flag.
//   Add-token reads then writes the counts before its result; alpha write and
//   no-op go straight to the result. A resample first decrements the counts,
//   then passes every topic weight through a split multiply (ST_MUL0, ST_MUL1)
//   and a 48-step shift-subtract divider (skipped when the weight saturates),
//   one topic at a time, then scans the cumulative table with a read and a
//   compare per entry, and at last increments the counts of the picked topic.
//   One item is in flight at a time; s_tready is high only when idle.
//   After reset a clearing pass sweeps the whole address range and zeroes the count
//   and alpha memories; s_tready stays low until it ends. Configuration
//   writes are taken at any time; change them only while idle.
//   A finished result sits in the output register; if the receiver stalls,
//   the block holds in its final step until the register frees up.
// ----------------------------------------------------------------------------
module lda_gibbs_topic_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// doc_index[9:0], word_id[21:10], topic[27:22], uniform[59:28],
	// hyper_value[91:60], zero pad [95:92]
	input  logic [95:0] s_tdata,
	// func[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// new_topic[5:0], zero pad [7:6]
	output logic [7:0]  m_tdata,
	// count_error[0]
	output logic [0:0]  m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW  = lgts_pkg::COUNT_BITS;
	localparam int TPW = lgts_pkg::TOPIC_W;
	localparam int OPW = lgts_pkg::OP_W;
	localparam int PW  = lgts_pkg::PROD_W;
	localparam int WW  = lgts_pkg::WGT_W;
	localparam int LOW = lgts_pkg::LO_W;
	localparam int DIV_CNT_W = $clog2(WW);

	localparam logic [4:0] ST_CLR    = 5'd0;
	localparam logic [4:0] ST_IDLE   = 5'd1;
	localparam logic [4:0] ST_DEC_RD = 5'd2;
	localparam logic [4:0] ST_DEC_WR = 5'd3;
	localparam logic [4:0] ST_W_RD   = 5'd4;
	localparam logic [4:0] ST_W_OPS  = 5'd5;
	localparam logic [4:0] ST_MUL0   = 5'd6;
	localparam logic [4:0] ST_MUL1   = 5'd7;
	localparam logic [4:0] ST_SAT    = 5'd8;
	localparam logic [4:0] ST_DIV    = 5'd9;
	localparam logic [4:0] ST_ACC    = 5'd10;
	localparam logic [4:0] ST_R0     = 5'd11;
	localparam logic [4:0] ST_R1     = 5'd12;
	localparam logic [4:0] ST_S_RD   = 5'd13;
	localparam logic [4:0] ST_S_CMP  = 5'd14;
	localparam logic [4:0] ST_INC_RD = 5'd15;
	localparam logic [4:0] ST_INC_WR = 5'd16;
	localparam logic [4:0] ST_DONE   = 5'd17;

	localparam logic [TPW-1:0] K_LAST = TPW'(lgts_pkg::NUM_TOPICS - 1);
	localparam logic [TPW-1:0] K_PEN  = TPW'(lgts_pkg::NUM_TOPICS - 2);

	// memories
	logic [CW-1:0] dt_mem [lgts_pkg::NUM_DOCS * lgts_pkg::NUM_TOPICS];
	logic [CW-1:0] tw_mem [lgts_pkg::NUM_TOPICS * lgts_pkg::VOCAB_SIZE];
	logic [CW-1:0] tot_mem [lgts_pkg::NUM_TOPICS];
	logic [31:0]   alpha_mem [lgts_pkg::NUM_TOPICS];
	logic [WW-1:0] cum_mem [lgts_pkg::NUM_TOPICS];

	logic [4:0] state_q;
	logic [lgts_pkg::TW_AW-1:0] clr_q;
	logic [31:0] beta_q, tbeta_q;

	logic [lgts_pkg::DOC_W-1:0]  doc_q;
	logic [lgts_pkg::WORD_W-1:0] word_q;
	logic [TPW-1:0] k_q;
	logic [31:0]    uni_q;
	logic           err_q;

	logic [CW-1:0] dt_rd_q, tw_rd_q, tot_rd_q;
	logic [31:0]   alpha_rd_q;
	logic [WW-1:0] cum_rd_q;

	logic [OPW-1:0] num_q, am_q, den_q;
	logic [PW-1:0]  prod_q;
	logic [OPW-1:0] rem_q;
	logic [WW-1:0]  dvd_q, quo_q, wgt_q, sum_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [63:0]    rp_q;
	logic [WW:0]    r_q;

	logic           out_v_q, out_err_q;
	logic [TPW-1:0] out_topic_q;

	logic accept;
	logic clearing;
	logic [lgts_pkg::DOC_W-1:0]  in_doc;
	logic [lgts_pkg::WORD_W-1:0] in_word;
	logic [TPW-1:0] in_topic;
	logic [31:0]    in_uni, in_hyp;

	assign in_doc   = s_tdata[9:0];
	assign in_word  = s_tdata[21:10];
	assign in_topic = s_tdata[27:22];
	assign in_uni   = s_tdata[59:28];
	assign in_hyp   = s_tdata[91:60];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign clearing = (state_q == ST_CLR);

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, out_topic_q};
	assign m_tuser  = out_err_q;

	// saturating count updates
	logic [CW-1:0] dt_dec, tw_dec, tot_dec, dt_inc, tw_inc, tot_inc;
	logic          dec_err;
	always_comb begin
		dt_dec  = (dt_rd_q == '0) ? '0 : dt_rd_q - CW'(1);
		tw_dec  = (tw_rd_q == '0) ? '0 : tw_rd_q - CW'(1);
		tot_dec = (tot_rd_q == '0) ? '0 : tot_rd_q - CW'(1);
		dec_err = (dt_rd_q == '0) || (tw_rd_q == '0) || (tot_rd_q == '0);
		dt_inc  = (dt_rd_q == lgts_pkg::CNT_MAX) ? dt_rd_q : dt_rd_q + CW'(1);
		tw_inc  = (tw_rd_q == lgts_pkg::CNT_MAX) ? tw_rd_q : tw_rd_q + CW'(1);
		tot_inc = (tot_rd_q == lgts_pkg::CNT_MAX) ? tot_rd_q : tot_rd_q + CW'(1);
	end

	// count memory write port: clear sweep, decrement or increment
	logic          cnt_we;
	logic [CW-1:0] dt_wd, tw_wd, tot_wd;
	logic [lgts_pkg::DT_AW-1:0] dt_addr;
	logic [lgts_pkg::TW_AW-1:0] tw_addr;
	logic [TPW-1:0] tot_addr;
	always_comb begin
		cnt_we   = clearing || (state_q == ST_DEC_WR) || (state_q == ST_INC_WR);
		dt_addr  = {doc_q, k_q};
		tw_addr  = {k_q, word_q};
		tot_addr = k_q;
		dt_wd    = dt_inc;
		tw_wd    = tw_inc;
		tot_wd   = tot_inc;
		if (clearing) begin
			dt_addr  = clr_q[lgts_pkg::DT_AW-1:0];
			tw_addr  = clr_q;
			tot_addr = clr_q[TPW-1:0];
			dt_wd    = '0;
			tw_wd    = '0;
			tot_wd   = '0;
		end else if (state_q == ST_DEC_WR) begin
			dt_wd  = dt_dec;
			tw_wd  = tw_dec;
			tot_wd = tot_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			dt_mem[dt_addr]   <= dt_wd;
			tw_mem[tw_addr]   <= tw_wd;
			tot_mem[tot_addr] <= tot_wd;
		end
		dt_rd_q  <= dt_mem[{doc_q, k_q}];
		tw_rd_q  <= tw_mem[{k_q, word_q}];
		tot_rd_q <= tot_mem[k_q];
	end

	// alpha memory: cleared by the sweep, written by the alpha function
	logic           alpha_we;
	logic [TPW-1:0] alpha_waddr;
	logic [31:0]    alpha_wd;
	always_comb begin
		alpha_we    = clearing || (accept && (s_tuser == lgts_pkg::FUNC_ALPHA));
		alpha_waddr = clearing ? clr_q[TPW-1:0] : in_topic;
		alpha_wd    = clearing ? 32'd0 : in_hyp;
	end

	always_ff @(posedge clk) begin
		if (alpha_we) begin
			alpha_mem[alpha_waddr] <= alpha_wd;
		end
		alpha_rd_q <= alpha_mem[k_q];
	end

	// cumulative weight table
	logic [WW:0]   sum_ext;
	logic [WW-1:0] sum_next;
	assign sum_ext  = {1'b0, sum_q} + {1'b0, wgt_q};
	assign sum_next = sum_ext[WW] ? lgts_pkg::WGT_MAX : sum_ext[WW-1:0];

	always_ff @(posedge clk) begin
		if (state_q == ST_ACC) begin
			cum_mem[k_q] <= sum_next;
		end
		cum_rd_q <= cum_mem[k_q];
	end

	// weight operands
	logic [OPW-1:0] num_c, am_c, den_c;
	always_comb begin
		num_c = {1'b0, tw_rd_q, 16'd0} + OPW'(beta_q);
		am_c  = {1'b0, dt_rd_q, 16'd0} + OPW'(alpha_rd_q);
		den_c = {1'b0, tot_rd_q, 16'd0} + OPW'(tbeta_q);
		if (den_c == '0) begin
			den_c = OPW'(1);
		end
	end

	// one shift-subtract step of the divider
	logic [OPW:0] rem_sh;
	logic         rem_ge;
	assign rem_sh = {rem_q, dvd_q[WW-1]};
	assign rem_ge = (rem_sh >= {1'b0, den_q});

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			beta_q  <= 32'd6554;
			tbeta_q <= 32'd26843546;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lgts_pkg::REG_BETA:       beta_q  <= cfg_data;
					lgts_pkg::REG_TOTAL_BETA: tbeta_q <= cfg_data;
					default: ;
				endcase
			end
			// load the output register when the result is done and it is free
			if ((state_q == ST_DONE) && (!out_v_q || m_tready)) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (s_tuser)
							lgts_pkg::FUNC_ADD: state_q <= ST_INC_RD;
							lgts_pkg::FUNC_RES: state_q <= ST_DEC_RD;
							default:            state_q <= ST_DONE;
						endcase
					end
				end
				ST_DEC_RD: state_q <= ST_DEC_WR;
				ST_DEC_WR: state_q <= ST_W_RD;
				ST_W_RD:   state_q <= ST_W_OPS;
				ST_W_OPS:  state_q <= ST_MUL0;
				ST_MUL0:   state_q <= ST_MUL1;
				ST_MUL1:   state_q <= ST_SAT;
				ST_SAT: begin
					state_q <= (prod_q[PW-1:32] >= (PW-32)'(den_q)) ? ST_ACC : ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC:    state_q <= (k_q == K_LAST) ? ST_R0 : ST_W_RD;
				ST_R0:     state_q <= ST_R1;
				ST_R1:     state_q <= ST_S_RD;
				ST_S_RD:   state_q <= ST_S_CMP;
				ST_S_CMP: begin
					if (({1'b0, cum_rd_q} >= r_q) || (k_q == K_PEN)) begin
						state_q <= ST_INC_RD;
					end else begin
						state_q <= ST_S_RD;
					end
				end
				ST_INC_RD: state_q <= ST_INC_WR;
				ST_INC_WR: state_q <= ST_DONE;
				ST_DONE: begin
					// hold until the output register is free
					if (!out_v_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					doc_q  <= in_doc;
					word_q <= in_word;
					k_q    <= in_topic;
					uni_q  <= in_uni;
					err_q  <= 1'b0;
				end
			end
			ST_DEC_WR: begin
				err_q <= dec_err;
				k_q   <= '0;
				sum_q <= '0;
			end
			ST_W_OPS: begin
				num_q <= num_c;
				am_q  <= am_c;
				den_q <= den_c;
			end
			ST_MUL0: prod_q <= PW'(num_q) * PW'(am_q[LOW-1:0]);
			ST_MUL1: prod_q <= prod_q + ((PW'(num_q) * PW'(am_q[OPW-1:LOW])) << LOW);
			ST_SAT: begin
				wgt_q     <= lgts_pkg::WGT_MAX;
				rem_q     <= prod_q[OPW+31:32];
				dvd_q     <= {prod_q[31:0], 16'd0};
				div_cnt_q <= DIV_CNT_W'(WW - 1);
			end
			ST_DIV: begin
				rem_q     <= rem_ge ? OPW'(rem_sh - {1'b0, den_q}) : rem_sh[OPW-1:0];
				dvd_q     <= {dvd_q[WW-2:0], 1'b0};
				quo_q     <= {quo_q[WW-2:0], rem_ge};
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == '0) begin
					wgt_q <= {quo_q[WW-2:0], rem_ge};
				end
			end
			ST_ACC: begin
				sum_q <= sum_next;
				k_q   <= (k_q == K_LAST) ? '0 : k_q + 1'b1;
			end
			ST_R0: rp_q <= uni_q * sum_q[31:0];
			ST_R1: r_q  <= (WW+1)'(uni_q) * (WW+1)'(sum_q[WW-1:32]) + (WW+1)'(rp_q[63:32]);
			ST_S_CMP: begin
				if (({1'b0, cum_rd_q} < r_q) && (k_q == K_PEN)) begin
					k_q <= K_LAST;
				end else if ({1'b0, cum_rd_q} < r_q) begin
					k_q <= k_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_v_q || m_tready) begin
					out_topic_q <= k_q;
					out_err_q   <= err_q;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lda_gibbs_topic_sampler
// Starts with a table of directed beats, then runs randomized add, resample,
// alpha and no-op beats across several prior settings. A local model of the
// count tables predicts each output beat, and a scoreboard compares the beats
// in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NUM_TOPICS = lgts_pkg::NUM_TOPICS;
	localparam int VOCAB_SIZE = lgts_pkg::VOCAB_SIZE;
	localparam int FUNC_W     = lgts_pkg::FUNC_W;
	localparam int DOC_W      = lgts_pkg::DOC_W;
	localparam int WORD_W     = lgts_pkg::WORD_W;
	localparam int TOPIC_W    = lgts_pkg::TOPIC_W;
	localparam int UNI_W      = lgts_pkg::UNI_W;
	localparam int HYP_W      = lgts_pkg::HYP_W;
	localparam int WGT_W      = lgts_pkg::WGT_W;

	// the block takes code 3 as a no-op; the package does not name it
	localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
	localparam longint CYCLE_LIMIT = 40_000_000;

	typedef struct {
		logic [FUNC_W-1:0]  func;
		logic [DOC_W-1:0]   doc;
		logic [WORD_W-1:0]  word;
		logic [TOPIC_W-1:0] topic;
		logic [UNI_W-1:0]   uni;
		logic [HYP_W-1:0]   hyper;
	} token_beat_t;

	typedef struct {
		logic [TOPIC_W-1:0] topic;
		logic               err;
	} topic_result_t;

	typedef struct {
		token_beat_t  beat;
		bit           typed;
		topic_result_t res;
	} stim_row_t;

	typedef struct {
		logic [DOC_W-1:0]   doc;
		logic [WORD_W-1:0]  word;
		logic [TOPIC_W-1:0] topic;
	} placed_token_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;

	// predicted count tables, sparse; a missing key reads as zero
	int unsigned      doc_topic_cnt[int];
	int unsigned      topic_word_cnt[int];
	int unsigned      topic_total_cnt[NUM_TOPICS];
	logic [HYP_W-1:0] alpha_prior[NUM_TOPICS];
	logic [31:0]      beta_prior;
	logic [31:0]      total_beta_prior;

	topic_result_t    pending_topics[$];
	stim_row_t        directed_rows[$];
	placed_token_t    placed_tokens[$];
	int               error_count = 0;
	longint           cycle_count = 0;
	int unsigned      accepted_beats = 0;
	bit               quiet;

	lda_gibbs_topic_sampler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic int unsigned cnt_get(ref int unsigned tbl[int], input int key);
		return tbl.exists(key) ? tbl[key] : 0;
	endfunction

	function automatic void cnt_bump(ref int unsigned tbl[int], input int key);
		int unsigned v;
		v = cnt_get(tbl, key);
		if (v < lgts_pkg::CNT_MAX) tbl[key] = v + 1;
	endfunction

	// returns 1 when the count was already zero and is left alone
	function automatic bit cnt_drop(ref int unsigned tbl[int], input int key);
		int unsigned v;
		v = cnt_get(tbl, key);
		if (v == 0) return 1'b1;
		tbl[key] = v - 1;
		return 1'b0;
	endfunction

	// floor(num*am*2^16/den), clipped to 48 bits
	function automatic logic [WGT_W-1:0] topic_weight(logic [63:0] num, logic [63:0] am,
			logic [63:0] den);
		logic [127:0] p;
		p = num;
		p = p * am;
		p = p << 16;
		p = p / den;
		return (p > lgts_pkg::WGT_MAX) ? lgts_pkg::WGT_MAX : p[WGT_W-1:0];
	endfunction

	function automatic topic_result_t sample_topic(token_beat_t b);
		topic_result_t      res;
		logic [WGT_W-1:0]   running[NUM_TOPICS];
		logic [WGT_W-1:0]   sum;
		logic [WGT_W-1:0]   w;
		logic [63:0]        num, den, am;
		logic [127:0]       target;
		int                 k;
		int                 pick;
		res.topic = b.topic;
		res.err   = 1'b0;
		case (b.func)
			lgts_pkg::FUNC_ALPHA: alpha_prior[b.topic] = b.hyper;
			lgts_pkg::FUNC_ADD: begin
				cnt_bump(doc_topic_cnt, b.doc * NUM_TOPICS + b.topic);
				cnt_bump(topic_word_cnt, b.topic * VOCAB_SIZE + b.word);
				if (topic_total_cnt[b.topic] < lgts_pkg::CNT_MAX)
					topic_total_cnt[b.topic]++;
			end
			lgts_pkg::FUNC_RES: begin
				// remove the token first; a zero count stays zero and flags
				res.err |= cnt_drop(doc_topic_cnt, b.doc * NUM_TOPICS + b.topic);
				res.err |= cnt_drop(topic_word_cnt, b.topic * VOCAB_SIZE + b.word);
				if (topic_total_cnt[b.topic] == 0) res.err = 1'b1;
				else topic_total_cnt[b.topic]--;
				sum = '0;
				for (k = 0; k < NUM_TOPICS; k++) begin
					num = (64'(cnt_get(topic_word_cnt, k * VOCAB_SIZE + b.word)) << 16)
						+ beta_prior;
					den = (64'(topic_total_cnt[k]) << 16) + total_beta_prior;
					am  = (64'(cnt_get(doc_topic_cnt, b.doc * NUM_TOPICS + k)) << 16)
						+ alpha_prior[k];
					if (den == 0) den = 1;
					w = topic_weight(num, am, den);
					sum = (lgts_pkg::WGT_MAX - sum < w) ? lgts_pkg::WGT_MAX : sum + w;
					running[k] = sum;
				end
				target = 128'(b.uni) * 128'(sum);
				target = target >> 32;
				pick = NUM_TOPICS - 1;
				for (k = NUM_TOPICS - 2; k >= 0; k--)
					if (128'(running[k]) >= target) pick = k;
				cnt_bump(doc_topic_cnt, b.doc * NUM_TOPICS + pick);
				cnt_bump(topic_word_cnt, pick * VOCAB_SIZE + b.word);
				if (topic_total_cnt[pick] < lgts_pkg::CNT_MAX) topic_total_cnt[pick]++;
				res.topic = TOPIC_W'(pick);
			end
			default: ;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// scoreboard: sample the output beat at the rising edge
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what);
		$display("[%0d] mismatch: %s", cycle_count, what);
		error_count++;
	endtask

	always @(posedge clk) begin
		topic_result_t exp_res;
		if (arst_n && s_tvalid && s_tready) accepted_beats++;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_topics.size() == 0) begin
				report_mismatch($sformatf("unexpected beat topic=%0d err=%0d",
					m_tdata[5:0], m_tuser[0]));
			end else begin
				exp_res = pending_topics.pop_front();
				if (m_tdata[5:0] !== exp_res.topic)
					report_mismatch($sformatf("new_topic %0d, want %0d",
						m_tdata[5:0], exp_res.topic));
				if (m_tuser[0] !== exp_res.err)
					report_mismatch($sformatf("count_error %0d, want %0d",
						m_tuser[0], exp_res.err));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver stalls at random, except through the quiet stretch
	always @(negedge clk)
		m_tready <= quiet || ($urandom_range(99) >= 34);

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == lgts_pkg::REG_BETA) beta_prior = val;
		else total_beta_prior = val;
	endtask

	task automatic drain_results();
		while (pending_topics.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// present one beat, hold it until taken, then maybe drop valid for a gap
	task automatic send_beat(token_beat_t b, bit typed, topic_result_t typed_res);
		topic_result_t pred;
		int unsigned   goal;
		pred = sample_topic(b);
		pending_topics.push_back(typed ? typed_res : pred);
		s_tdata  = {4'b0, b.hyper, b.uni, b.topic, b.word, b.doc};
		s_tuser  = b.func;
		s_tvalid = 1'b1;
		goal = accepted_beats + 1;
		while (accepted_beats != goal) @(negedge clk);
		if (!quiet && $urandom_range(99) < 34) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic add_row(logic [FUNC_W-1:0] f, logic [DOC_W-1:0] d,
			logic [WORD_W-1:0] w, logic [TOPIC_W-1:0] t, logic [31:0] u,
			logic [31:0] h, bit typed, logic [TOPIC_W-1:0] et, logic ee);
		stim_row_t r;
		r.beat = '{f, d, w, t, u, h};
		r.typed = typed;
		r.res = '{et, ee};
		directed_rows.push_back(r);
	endtask

	function automatic token_beat_t random_beat();
		token_beat_t   b;
		placed_token_t pt;
		int            sel;
		int            idx;
		b.uni   = $urandom();
		if (b.uni == 0) b.uni = 1;
		b.hyper = $urandom();
		// most tokens land on a few documents and words so counts build up
		b.doc   = DOC_W'(($urandom_range(9) == 0) ? $urandom() : $urandom_range(7));
		b.word  = WORD_W'(($urandom_range(9) == 0) ? $urandom() : $urandom_range(31));
		b.topic = TOPIC_W'($urandom());
		sel = $urandom_range(99);
		if (sel < 35) begin
			b.func = lgts_pkg::FUNC_ADD;
			pt = '{b.doc, b.word, b.topic};
			if (placed_tokens.size() < 200) placed_tokens.push_back(pt);
		end else if (sel < 65 && placed_tokens.size() != 0) begin
			idx = $urandom_range(placed_tokens.size() - 1);
			b.func  = lgts_pkg::FUNC_RES;
			b.doc   = placed_tokens[idx].doc;
			b.word  = placed_tokens[idx].word;
			b.topic = placed_tokens[idx].topic;
		end else if (sel < 70) begin
			b.func = lgts_pkg::FUNC_RES;   // token never placed: decrement refused
		end else if (sel < 85) begin
			b.func = lgts_pkg::FUNC_ALPHA;
		end else begin
			b.func = FUNC_NOP;
		end
		return b;
	endfunction

	initial begin
		token_beat_t   b;
		topic_result_t none;
		topic_result_t pred;
		int            n;
		int            p;
		int            idx;

		quiet            = 1'b0;
		beta_prior       = 32'd6554;
		total_beta_prior = 32'd26843546;
		for (n = 0; n < NUM_TOPICS; n++) begin
			topic_total_cnt[n] = 0;
			alpha_prior[n] = '0;
		end
		none = '{0, 0};
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 1'b0;
		cfg_index = 1'b0;
		cfg_data  = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed table: no-op, empty-table resample, alpha writes, adds at the
		// field extremes, a no-op, then resamples checked by prediction around an alpha write
		add_row(FUNC_NOP, 5, 9, 5, 32'h1, 32'h0, 1, 5, 0);
		add_row(lgts_pkg::FUNC_RES, 0, 0, 0, 32'hFFFF_FFFF, 32'h0, 1, 0, 1);
		add_row(lgts_pkg::FUNC_ALPHA, 0, 0, 0, 32'h1, 32'hFFFF_FFFF, 1, 0, 0);
		add_row(lgts_pkg::FUNC_ALPHA, 1023, 4095, 63, 32'h8000_0000, 32'h0, 1, 63, 0);
		add_row(lgts_pkg::FUNC_ALPHA, 3, 7, 31, 32'h1, 32'h0001_0000, 1, 31, 0);
		add_row(lgts_pkg::FUNC_ADD, 1023, 4095, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 63, 0);
		add_row(lgts_pkg::FUNC_ADD, 0, 0, 0, 32'h1, 32'h0, 1, 0, 0);
		add_row(lgts_pkg::FUNC_ADD, 0, 4095, 63, 32'h1, 32'h0, 1, 63, 0);
		add_row(lgts_pkg::FUNC_ADD, 1023, 0, 31, 32'h1, 32'h0, 1, 31, 0);
		add_row(FUNC_NOP, 1023, 4095, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 63, 0);
		add_row(lgts_pkg::FUNC_RES, 1023, 4095, 63, 32'h1, 32'h0, 0, 0, 0);
		add_row(lgts_pkg::FUNC_RES, 0, 0, 0, 32'hFFFF_FFFF, 32'h0, 0, 0, 0);
		add_row(lgts_pkg::FUNC_RES, 0, 4095, 63, 32'h8000_0000, 32'h0, 0, 0, 0);
		add_row(lgts_pkg::FUNC_RES, 1023, 0, 31, 32'h0000_0001, 32'h0, 0, 0, 0);
		add_row(lgts_pkg::FUNC_RES, 512, 2048, 32, 32'h4000_0000, 32'h0, 0, 0, 0);
		add_row(lgts_pkg::FUNC_ALPHA, 0, 0, 63, 32'h1, 32'hFFFF_FFFF, 1, 63, 0);
		add_row(lgts_pkg::FUNC_RES, 1023, 4095, 7, 32'hFFFF_FFFF, 32'h0, 0, 0, 0);
		foreach (directed_rows[i])
			send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].res);
		@(negedge clk);
		s_tvalid = 1'b0;
		drain_results();

		// random phases, each under its own priors
		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin
					write_reg(lgts_pkg::REG_BETA, 32'd6554);
					write_reg(lgts_pkg::REG_TOTAL_BETA, 32'd26843546);
				end
				1: begin
					write_reg(lgts_pkg::REG_BETA, 32'h0);
					write_reg(lgts_pkg::REG_TOTAL_BETA, 32'hFFFF_FFFF);
				end
				2: begin
					// huge numerator over a tiny divisor: weights and sums clip
					write_reg(lgts_pkg::REG_BETA, 32'hFFFF_FFFF);
					write_reg(lgts_pkg::REG_TOTAL_BETA, 32'h1);
				end
				default: begin
					write_reg(lgts_pkg::REG_BETA, $urandom());
					write_reg(lgts_pkg::REG_TOTAL_BETA, $urandom_range(32'hFFFF_FFFF, 1));
				end
			endcase
			for (n = 0; n < 420; n++) begin
				quiet = (p == 1) && (n >= 100) && (n < 300);
				if (p == 0 && n == 200) begin
					// hold the sender until the output side has caught up
					@(negedge clk);
					s_tvalid = 1'b0;
					drain_results();
				end
				@(negedge clk);
				send_beat(random_beat(), 0, none);
				// keep tracked tokens on the topic they were resampled to
				b.func = s_tuser;
				if (b.func == lgts_pkg::FUNC_RES && placed_tokens.size() != 0) begin
					pred = pending_topics[pending_topics.size() - 1];
					foreach (placed_tokens[i])
						if (placed_tokens[i].doc == s_tdata[9:0]
								&& placed_tokens[i].word == s_tdata[21:10]
								&& placed_tokens[i].topic == s_tdata[27:22]) begin
							idx = i;
							placed_tokens[idx].topic = pred.topic;
							break;
						end
				end
			end
			quiet = 1'b0;
			@(negedge clk);
			s_tvalid = 1'b0;
			drain_results();
		end

		repeat (50) @(negedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
